// ===== hdl/lattice_neighbor_address_macros.svh =====
// Assertion macros shared by the lattice neighbor address block.
`ifndef LATTICE_NEIGHBOR_ADDRESS_MACROS_SVH
`define LATTICE_NEIGHBOR_ADDRESS_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define LNA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lattice_neighbor_address: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define LNA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lattice_neighbor_address: next-cycle check failed");

`else

`define LNA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define LNA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/lna_pkg.sv =====
package lna_pkg;

    // Lattice limits.
    localparam int MAX_SIDE = 1024;
    localparam int MAX_AXES = 3;
    localparam int NUM_AXES = 3;

    // Field widths.
    localparam int CRD_W  = 10;
    localparam int LEN_W  = 11;
    localparam int DIMS_W = 2;
    localparam int MASK_W = 3;
    localparam int DIR_W  = 3;
    localparam int SITE_W = 30;
    localparam int WIDE_W = CRD_W + LEN_W;

    // Index of a midpoint in the remainder steps: the upper half runs in the first stage.
    localparam int REM_SPLIT = CRD_W / 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_DIMS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_FAST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_MID      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_SLOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_MASK = 3'd4;

    // Register values after reset.
    localparam logic [DIMS_W-1:0] RST_SPACE_DIMS    = 2'd3;
    localparam logic [LEN_W-1:0]  RST_SIZE          = 11'd64;
    localparam logic [MASK_W-1:0] RST_PERIODIC_MASK = 3'd7;

    typedef logic [CRD_W-1:0] t_crd;
    typedef logic [LEN_W-1:0] t_len;
    typedef logic [NUM_AXES-1:0][LEN_W-1:0] t_len_vec;
    typedef logic [NUM_AXES-1:0][CRD_W-1:0] t_crd_vec;

    // Input beat: one lattice site.
    typedef struct packed {
        logic [CRD_W-1:0] coord_slow;
        logic [CRD_W-1:0] coord_mid;
        logic [CRD_W-1:0] coord_fast;
    } t_in_beat;

    // Output beat: one neighbor.
    typedef struct packed {
        logic [DIR_W-1:0]  direction;
        logic [SITE_W-1:0] neighbor_site;
        logic              off_lattice;
        logic              last;
    } t_out_beat;

    // Coordinates of a site as a vector indexed by axis.
    function automatic t_crd_vec f_crd_vec(input t_in_beat b);
        t_crd_vec v;
        v[0] = b.coord_fast;
        v[1] = b.coord_mid;
        v[2] = b.coord_slow;
        return v;
    endfunction

    // One restoring step of x mod d: subtract d shifted by sh when it fits.
    function automatic t_crd f_rem_step(input t_crd x, input t_len d, input int unsigned sh);
        logic [WIDE_W-1:0] ds;
        logic [WIDE_W-1:0] xw;
        ds = WIDE_W'(d) << sh;
        xw = WIDE_W'(x);
        if (xw >= ds) begin
            return CRD_W'(xw - ds);
        end
        return x;
    endfunction

    // Axis length with zero read as one and oversize read as the maximum.
    function automatic t_len f_clamp_len(input t_len v);
        if (v == '0) begin
            return LEN_W'(1);
        end else if (int'(v) > MAX_SIDE) begin
            return LEN_W'(MAX_SIDE);
        end
        return v;
    endfunction

    // Axis count with zero read as one and oversize read as the maximum.
    function automatic logic [DIMS_W-1:0] f_clamp_axes(input logic [DIMS_W-1:0] v);
        if (v == '0) begin
            return DIMS_W'(1);
        end else if (int'(v) > MAX_AXES) begin
            return DIMS_W'(MAX_AXES);
        end
        return v;
    endfunction

endpackage

// ===== hdl/lna_front.sv =====
// Two-stage front end: captures a site and reduces each coordinate modulo its axis
// length with a restoring remainder, half of the quotient bits in each stage.
module lna_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lna_pkg::t_in_beat i_beat,
    input  lna_pkg::t_len_vec i_len,
    input  logic              i_take,
    output logic              o_ready,
    output logic              o_valid,
    output lna_pkg::t_in_beat o_beat,
    output lna_pkg::t_crd_vec o_rem
);

    logic              r_v1;
    logic              r_v2;
    lna_pkg::t_in_beat r_c1;
    lna_pkg::t_in_beat r_c2;
    lna_pkg::t_crd_vec r_rem1;
    lna_pkg::t_crd_vec r_rem2;
    lna_pkg::t_crd_vec n_rem1;
    lna_pkg::t_crd_vec n_rem2;
    logic              ld1;
    logic              ld2;

    // A stage loads when it is empty or its beat moves on.
    assign ld2 = !r_v2 || i_take;
    assign ld1 = !r_v1 || ld2;

    // Upper remainder steps on the incoming coordinates.
    always_comb begin
        lna_pkg::t_crd_vec crd;
        lna_pkg::t_crd     x;
        crd = lna_pkg::f_crd_vec(i_beat);
        for (int k = 0; k < lna_pkg::NUM_AXES; k++) begin
            x = crd[k];
            for (int s = lna_pkg::CRD_W - 1; s >= lna_pkg::REM_SPLIT; s--) begin
                x = lna_pkg::f_rem_step(x, i_len[k], s);
            end
            n_rem1[k] = x;
        end
    end

    // Lower remainder steps on the partial remainders.
    always_comb begin
        lna_pkg::t_crd x;
        for (int k = 0; k < lna_pkg::NUM_AXES; k++) begin
            x = r_rem1[k];
            for (int s = lna_pkg::REM_SPLIT - 1; s >= 0; s--) begin
                x = lna_pkg::f_rem_step(x, i_len[k], s);
            end
            n_rem2[k] = x;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= i_valid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_c1   <= i_beat;
            r_rem1 <= n_rem1;
        end
        if (ld2) begin
            r_c2   <= r_c1;
            r_rem2 <= n_rem2;
        end
    end

    assign o_ready = ld1;
    assign o_valid = r_v2;
    assign o_beat  = r_c2;
    assign o_rem   = r_rem2;

endmodule

// ===== hdl/lattice_neighbor_address.sv =====
// Path: a site's beat passes the two front-end stages, the direction sequencer, the
// neighbor coordinate stage, the first multiply stage and the output register.
// The direction sequencer emits 2*D neighbors per site (2, 4 or 6), one per cycle while
// the output is not stalled, and takes the next site only with its final direction.
// Reset: synchronous, active low; empties the pipeline and restores the register defaults.
`include "lattice_neighbor_address_macros.svh"

module lattice_neighbor_address (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  lna_pkg::t_in_beat                   i_in_beat,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output lna_pkg::t_out_beat                  o_out_beat,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lna_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lna_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Configuration registers.
    logic [lna_pkg::DIMS_W-1:0] r_space_dims;
    lna_pkg::t_len              r_size_fast;
    lna_pkg::t_len              r_size_mid;
    lna_pkg::t_len              r_size_slow;
    logic [lna_pkg::MASK_W-1:0] r_periodic_mask;

    lna_pkg::t_len_vec          len;
    logic [lna_pkg::DIMS_W-1:0] axes;
    logic [lna_pkg::DIR_W-1:0]  last_dir;

    // Front end.
    logic              front_ready;
    logic              front_valid;
    lna_pkg::t_in_beat front_beat;
    lna_pkg::t_crd_vec front_rem;

    // Direction sequencer stage.
    logic                      r_v3;
    lna_pkg::t_in_beat         r_c3;
    lna_pkg::t_crd_vec         r_rem3;
    logic [lna_pkg::DIR_W-1:0] r_dir;
    logic                      take;

    // Neighbor coordinate stage.
    logic                      r_v4;
    lna_pkg::t_crd_vec         r_nb4;
    logic                      r_off4;
    logic [lna_pkg::DIR_W-1:0] r_dir4;
    logic                      r_last4;
    lna_pkg::t_crd_vec         n_nb4;
    logic                      n_off4;

    // First multiply stage.
    logic                                    r_v5;
    logic [2*lna_pkg::CRD_W-1:0]             r_t5;
    lna_pkg::t_crd                           r_c0_5;
    logic                                    r_off5;
    logic [lna_pkg::DIR_W-1:0]               r_dir5;
    logic                                    r_last5;
    logic [lna_pkg::WIDE_W-1:0]              n_t5;

    // Output register.
    logic                      r_v6;
    lna_pkg::t_out_beat        r_out6;
    logic [lna_pkg::SITE_W:0]  n_site6;

    logic en4;
    logic en5;
    logic en6;

    // Configuration writes; the port never back-pressures.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_dims    <= lna_pkg::RST_SPACE_DIMS;
            r_size_fast     <= lna_pkg::RST_SIZE;
            r_size_mid      <= lna_pkg::RST_SIZE;
            r_size_slow     <= lna_pkg::RST_SIZE;
            r_periodic_mask <= lna_pkg::RST_PERIODIC_MASK;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lna_pkg::CFG_SPACE_DIMS: begin
                    r_space_dims <= i_cfg_data[lna_pkg::DIMS_W-1:0];
                end
                lna_pkg::CFG_SIZE_FAST: begin
                    r_size_fast <= i_cfg_data[lna_pkg::LEN_W-1:0];
                end
                lna_pkg::CFG_SIZE_MID: begin
                    r_size_mid <= i_cfg_data[lna_pkg::LEN_W-1:0];
                end
                lna_pkg::CFG_SIZE_SLOW: begin
                    r_size_slow <= i_cfg_data[lna_pkg::LEN_W-1:0];
                end
                lna_pkg::CFG_PERIODIC_MASK: begin
                    r_periodic_mask <= i_cfg_data[lna_pkg::MASK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective lengths and axis count.
    assign len[0]   = lna_pkg::f_clamp_len(r_size_fast);
    assign len[1]   = lna_pkg::f_clamp_len(r_size_mid);
    assign len[2]   = lna_pkg::f_clamp_len(r_size_slow);
    assign axes     = lna_pkg::f_clamp_axes(r_space_dims);
    assign last_dir = {axes, 1'b0} - lna_pkg::DIR_W'(1);

    // Stage enables: each stage moves when it is empty or the next one moves.
    assign en6 = !r_v6 || !i_out_stall;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;

    // The sequencer takes a new site when it is empty or emits its final direction.
    assign take = !r_v3 || ((r_dir == last_dir) && en4);

    lna_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_beat  (i_in_beat),
        .i_len   (len),
        .i_take  (take),
        .o_ready (front_ready),
        .o_valid (front_valid),
        .o_beat  (front_beat),
        .o_rem   (front_rem)
    );

    assign o_in_stall = !front_ready;

    // Sequencer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3  <= 1'b0;
            r_dir <= '0;
        end else begin
            if (take) begin
                r_v3 <= front_valid;
            end
            if (r_v3 && en4) begin
                r_dir <= (r_dir == last_dir) ? '0 : r_dir + lna_pkg::DIR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_c3   <= front_beat;
            r_rem3 <= front_rem;
        end
    end

    // Neighbor coordinates for the current direction. Periodic axes use the reduced
    // coordinate and wrap; open axes use the raw coordinate and flag the edge.
    always_comb begin
        lna_pkg::t_crd_vec crd;
        logic [lna_pkg::LEN_W-1:0] c11;
        logic [lna_pkg::LEN_W-1:0] r11;
        logic                      stepped;
        crd    = lna_pkg::f_crd_vec(r_c3);
        n_off4 = 1'b0;
        for (int k = 0; k < lna_pkg::NUM_AXES; k++) begin
            c11     = lna_pkg::LEN_W'(crd[k]);
            r11     = lna_pkg::LEN_W'(r_rem3[k]);
            stepped = (int'(r_dir[lna_pkg::DIR_W-1:1]) == k);
            if (k >= int'(axes)) begin
                n_nb4[k] = '0;
            end else if (r_periodic_mask[k]) begin
                if (stepped && r_dir[0]) begin
                    n_nb4[k] = (r11 + lna_pkg::LEN_W'(1) == len[k]) ? '0 :
                               r_rem3[k] + lna_pkg::CRD_W'(1);
                end else if (stepped) begin
                    n_nb4[k] = (r_rem3[k] == '0) ?
                               lna_pkg::CRD_W'(len[k] - lna_pkg::LEN_W'(1)) :
                               r_rem3[k] - lna_pkg::CRD_W'(1);
                end else begin
                    n_nb4[k] = r_rem3[k];
                end
            end else begin
                if (stepped && r_dir[0]) begin
                    n_nb4[k] = crd[k] + lna_pkg::CRD_W'(1);
                    if (c11 + lna_pkg::LEN_W'(1) >= len[k]) begin
                        n_off4 = 1'b1;
                    end
                end else if (stepped) begin
                    n_nb4[k] = crd[k] - lna_pkg::CRD_W'(1);
                    if ((crd[k] == '0) || (c11 > len[k])) begin
                        n_off4 = 1'b1;
                    end
                end else begin
                    n_nb4[k] = crd[k];
                    if (c11 >= len[k]) begin
                        n_off4 = 1'b1;
                    end
                end
            end
        end
    end

    // Index of the upper axes: c1 + L1 * c2.
    assign n_t5 = lna_pkg::WIDE_W'(len[1]) * lna_pkg::WIDE_W'(r_nb4[2])
                + lna_pkg::WIDE_W'(r_nb4[1]);

    // Full index: c0 + L0 * (c1 + L1 * c2).
    assign n_site6 = (lna_pkg::SITE_W + 1)'(len[0]) * (lna_pkg::SITE_W + 1)'(r_t5)
                   + (lna_pkg::SITE_W + 1)'(r_c0_5);

    // Back pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
            if (en6) begin
                r_v6 <= r_v5;
            end
        end
    end

    // Back pipeline payload.
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_nb4   <= n_nb4;
            r_off4  <= n_off4;
            r_dir4  <= r_dir;
            r_last4 <= (r_dir == last_dir);
        end
        if (en5) begin
            r_t5    <= n_t5[2*lna_pkg::CRD_W-1:0];
            r_c0_5  <= r_nb4[0];
            r_off5  <= r_off4;
            r_dir5  <= r_dir4;
            r_last5 <= r_last4;
        end
        if (en6) begin
            r_out6.direction     <= r_dir5;
            r_out6.neighbor_site <= r_off5 ? '0 : n_site6[lna_pkg::SITE_W-1:0];
            r_out6.off_lattice   <= r_off5;
            r_out6.last          <= r_last5;
        end
    end

    assign o_out_valid = r_v6;
    assign o_out_beat  = r_out6;

    // Checks.
    `LNA_ASSERT_IMPLY(a_off_zero, i_clk, i_rst_n, o_out_valid && o_out_beat.off_lattice, o_out_beat.neighbor_site == '0)
    `LNA_ASSERT_IMPLY(a_idle_dir, i_clk, i_rst_n, !r_v3, r_dir == '0)
    `LNA_ASSERT_NEXT(a_emit, i_clk, i_rst_n, r_v3 && en4, r_v4)

endmodule
